### hw/rtl/mcu_timer_port_registers_macros.svh
// Assertion macros shared by the timer and port register window.
`ifndef MCU_TIMER_PORT_REGISTERS_MACROS_SVH
`define MCU_TIMER_PORT_REGISTERS_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MTPR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mtpr_pkg.sv
// Shared types and address codes for the timer and port register window.
package mtpr_pkg;

  // Access kind.
  localparam logic CMD_WRITE = 1'b1;

  // Register addresses with special behaviour.
  localparam logic [4:0] ADDR_PORT1   = 5'h02;
  localparam logic [4:0] ADDR_PORT2   = 5'h03;
  localparam logic [4:0] ADDR_STATUS  = 5'h08;
  localparam logic [4:0] ADDR_CNT_HI  = 5'h09;
  localparam logic [4:0] ADDR_CNT_LO  = 5'h0A;
  localparam logic [4:0] ADDR_CMP_HI  = 5'h0B;
  localparam logic [4:0] ADDR_CMP_LO  = 5'h0C;

  // Status register bits.
  localparam logic [7:0] STATUS_WR_MASK = 8'h1F;
  localparam logic [7:0] FLAG_OCF       = 8'h40;
  localparam logic [7:0] FLAG_TOF       = 8'h20;

  localparam int unsigned FILE_DEPTH = 32;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  reg_addr;
    logic [7:0]  write_data;
    logic [15:0] counter_now;
    logic [7:0]  port_two_in;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        counter_load;
    logic [15:0] compare_value;
    logic [7:0]  column_select;
  } rsp_t;

  // Present state seen by the access decoder.
  typedef struct packed {
    logic [7:0]  rd_byte;
    logic [7:0]  status;
    logic [7:0]  port1;
    logic [7:0]  latch;
    logic [15:0] compare;
  } state_t;

  // Updates requested by the access decoder.
  typedef struct packed {
    logic        file_we;
    logic [4:0]  file_addr;
    logic [7:0]  file_data;
    logic        stat_we;
    logic [7:0]  stat_data;
    logic        latch_we;
    logic [7:0]  latch_data;
    logic        cmp_we;
    logic [15:0] cmp_data;
  } upd_t;

endpackage

### hw/rtl/mtpr_req_if.sv
// Request channel carrying one bus access.
interface mtpr_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [4:0]  reg_addr;
  logic [7:0]  write_data;
  logic [15:0] counter_now;
  logic [7:0]  port_two_in;

  modport source (output valid, cmd, reg_addr, write_data, counter_now, port_two_in,
                  input ready);
  modport sink (input valid, cmd, reg_addr, write_data, counter_now, port_two_in,
                output ready);
endinterface

### hw/rtl/mtpr_rsp_if.sv
// Result channel carrying the outcome of one bus access.
interface mtpr_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        counter_load;
  logic [15:0] compare_value;
  logic [7:0]  column_select;

  modport source (output valid, read_data, counter_load, compare_value, column_select,
                  input ready);
  modport sink (input valid, read_data, counter_load, compare_value, column_select,
                output ready);
endinterface

### hw/rtl/mcu_timer_port_registers.sv
// Top level of the timer and port register window.
//
//   Channel  Direction  Moves
//   req      in         one bus access: cmd, reg_addr, write_data, counter_now, port_two_in
//   rsp      out        read_data, counter_load, compare_value, column_select
//
// A request is registered at the input, then decoded and applied to the register
// file as its result is registered, once the result register can take it; one
// request per cycle is sustained while rsp is ready. Reset clears the register
// file, the latch, the compare value and both stage valids.
// A stall on rsp holds the result; req stays ready while the input stage can move.
`include "mcu_timer_port_registers_macros.svh"

module mcu_timer_port_registers (
  input logic    clk,
  input logic    rst,
  mtpr_req_if.sink   req,
  mtpr_rsp_if.source rsp
);

  logic             in_valid;
  mtpr_pkg::req_t   in_q;
  logic             out_valid;
  mtpr_pkg::rsp_t   out_q;
  logic             advance;
  mtpr_pkg::state_t cur;
  mtpr_pkg::upd_t   upd;
  mtpr_pkg::rsp_t   rsp_next;
  logic             in_stall;
  logic             load_with_data;
  logic             cmp_write;
  logic             ocf_set;

  // Stage movement.
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_q <= '{cmd: req.cmd, reg_addr: req.reg_addr, write_data: req.write_data,
                counter_now: req.counter_now, port_two_in: req.port_two_in};
    end
  end

  mtpr_access u_access (
    .req (in_q),
    .cur (cur),
    .upd (upd),
    .rsp (rsp_next)
  );

  mtpr_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .we      (advance),
    .rd_addr (in_q.reg_addr),
    .upd     (upd),
    .cur     (cur)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_q <= rsp_next;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_data     = out_q.read_data;
  assign rsp.counter_load  = out_q.counter_load;
  assign rsp.compare_value = out_q.compare_value;
  assign rsp.column_select = out_q.column_select;

  // Terms watched by the checks below.
  assign in_stall       = in_valid && !advance;
  assign load_with_data = out_q.counter_load && (out_q.read_data != 8'h00);
  assign cmp_write      = (in_q.cmd == mtpr_pkg::CMD_WRITE) &&
                          ((in_q.reg_addr == mtpr_pkg::ADDR_CMP_HI) ||
                           (in_q.reg_addr == mtpr_pkg::ADDR_CMP_LO));
  assign ocf_set        = |(cur.status & mtpr_pkg::FLAG_OCF);

  // A counter load only comes from a write, so no byte is returned with it.
  `MTPR_ASSERT_NOW(a_load_no_data, clk, rst, out_valid, !load_with_data, "counter load with read data")

  // A request held in the input stage keeps its contents until it moves on.
  `MTPR_ASSERT_NEXT(a_in_hold, clk, rst, in_stall, in_valid && $stable(in_q), "input stage lost a request")

  // A compare write leaves the output-compare flag clear.
  `MTPR_ASSERT_NEXT(a_ocf_clear, clk, rst, advance && cmp_write, !ocf_set, "compare write left flag set")

endmodule

### hw/rtl/mtpr_access.sv
// Access decoder: works out the result and the register updates for one request.
module mtpr_access (
  input  mtpr_pkg::req_t   req,
  input  mtpr_pkg::state_t cur,
  output mtpr_pkg::upd_t   upd,
  output mtpr_pkg::rsp_t   rsp
);

  logic [7:0] port1_next;

  // Decode the address and build the updates and the returned byte.
  always_comb begin
    upd                = '0;
    upd.file_addr      = req.reg_addr;
    upd.file_data      = req.write_data;
    upd.latch_data     = req.counter_now[7:0];
    upd.cmp_data       = cur.compare;
    upd.stat_data      = cur.status;
    rsp.read_data      = 8'h00;
    rsp.counter_load   = 1'b0;
    port1_next         = cur.port1;
    if (req.cmd == mtpr_pkg::CMD_WRITE) begin
      unique case (req.reg_addr)
        mtpr_pkg::ADDR_STATUS: begin
          upd.file_we   = 1'b1;
          upd.file_data = (cur.status & ~mtpr_pkg::STATUS_WR_MASK) |
                          (req.write_data & mtpr_pkg::STATUS_WR_MASK);
        end
        mtpr_pkg::ADDR_CNT_HI: begin
          rsp.counter_load = 1'b1;
        end
        mtpr_pkg::ADDR_CNT_LO: begin
          // Writes to the counter low byte have no effect.
        end
        mtpr_pkg::ADDR_CMP_HI: begin
          upd.file_we   = 1'b1;
          upd.stat_we   = 1'b1;
          upd.stat_data = cur.status & ~mtpr_pkg::FLAG_OCF;
          upd.cmp_we    = 1'b1;
          upd.cmp_data  = {req.write_data, cur.compare[7:0]};
        end
        mtpr_pkg::ADDR_CMP_LO: begin
          upd.file_we   = 1'b1;
          upd.stat_we   = 1'b1;
          upd.stat_data = cur.status & ~mtpr_pkg::FLAG_OCF;
          upd.cmp_we    = 1'b1;
          upd.cmp_data  = {cur.compare[15:8], req.write_data};
        end
        default: begin
          upd.file_we = 1'b1;
          if (req.reg_addr == mtpr_pkg::ADDR_PORT1) begin
            port1_next = req.write_data;
          end
        end
      endcase
    end else begin
      unique case (req.reg_addr)
        mtpr_pkg::ADDR_PORT2: begin
          rsp.read_data = req.port_two_in;
        end
        mtpr_pkg::ADDR_CNT_HI: begin
          // Reading the high byte clears the overflow flag and latches the low byte.
          upd.stat_we   = 1'b1;
          upd.stat_data = cur.status & ~mtpr_pkg::FLAG_TOF;
          upd.latch_we  = 1'b1;
          rsp.read_data = req.counter_now[15:8];
        end
        mtpr_pkg::ADDR_CNT_LO: begin
          rsp.read_data = cur.latch;
        end
        default: begin
          rsp.read_data = cur.rd_byte;
        end
      endcase
    end
    rsp.compare_value = upd.cmp_data;
    rsp.column_select = port1_next;
  end

endmodule

### hw/rtl/mtpr_regfile.sv
// Register window storage: 32 bytes, the counter low-byte latch and the compare value.
module mtpr_regfile (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [4:0]       rd_addr,
  input  mtpr_pkg::upd_t   upd,
  output mtpr_pkg::state_t cur
);

  logic [7:0]  mem [mtpr_pkg::FILE_DEPTH];
  logic [7:0]  latch;
  logic [15:0] compare;

  // Apply the updates of the request that is leaving the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mtpr_pkg::FILE_DEPTH; i++) begin
        mem[i] <= 8'h00;
      end
      latch   <= 8'h00;
      compare <= 16'h0000;
    end else if (we) begin
      if (upd.file_we) begin
        mem[upd.file_addr] <= upd.file_data;
      end
      if (upd.stat_we) begin
        mem[mtpr_pkg::ADDR_STATUS] <= upd.stat_data;
      end
      if (upd.latch_we) begin
        latch <= upd.latch_data;
      end
      if (upd.cmp_we) begin
        compare <= upd.cmp_data;
      end
    end
  end

  // Present state for the decoder.
  assign cur.rd_byte = mem[rd_addr];
  assign cur.status  = mem[mtpr_pkg::ADDR_STATUS];
  assign cur.port1   = mem[mtpr_pkg::ADDR_PORT1];
  assign cur.latch   = latch;
  assign cur.compare = compare;

endmodule

### tb/tb_top.sv
// Testbench for the timer and port register window: random and directed bus accesses.
`timescale 1ns / 100ps

module tb_top;

  localparam logic CMD_READ = ~mtpr_pkg::CMD_WRITE;
  localparam int RANDOM_ACCESSES = 1150;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PRINT_LIMIT = 40;

  // Which side of the handshake holds back, as the run progresses.
  typedef enum logic [1:0] {
    SENDER_LIGHT,
    RECEIVER_LIGHT,
    NO_IDLING
  } idle_mode_t;

  logic clk = 1'b0;
  logic rst;

  mtpr_req_if req_if ();
  mtpr_rsp_if rsp_if ();

  mcu_timer_port_registers dut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register window, updated as each request is accepted.
  logic [7:0]  shadow_regs [mtpr_pkg::FILE_DEPTH];
  logic [7:0]  shadow_latch;
  logic [15:0] shadow_compare;

  mtpr_pkg::req_t pending_accesses[$];
  mtpr_pkg::rsp_t expected_results[$];
  mtpr_pkg::req_t next_access;
  mtpr_pkg::req_t req_seen;
  mtpr_pkg::rsp_t rsp_seen;
  int   accepted_count = 0;
  int   total_accesses = 0;
  int   error_count = 0;
  int   stall_cycles = 0;

  assign req_seen = {req_if.cmd, req_if.reg_addr, req_if.write_data, req_if.counter_now,
                     req_if.port_two_in};
  assign rsp_seen = {rsp_if.read_data, rsp_if.counter_load, rsp_if.compare_value,
                     rsp_if.column_select};

  // Applies one access to the shadow state and returns the result it must produce.
  function automatic mtpr_pkg::rsp_t apply_access(mtpr_pkg::req_t a);
    mtpr_pkg::rsp_t r;
    r = '0;
    if (a.cmd == mtpr_pkg::CMD_WRITE) begin
      case (a.reg_addr)
        mtpr_pkg::ADDR_STATUS: begin
          shadow_regs[mtpr_pkg::ADDR_STATUS] =
              (shadow_regs[mtpr_pkg::ADDR_STATUS] & ~mtpr_pkg::STATUS_WR_MASK) |
              (a.write_data & mtpr_pkg::STATUS_WR_MASK);
        end
        mtpr_pkg::ADDR_CNT_HI: begin
          r.counter_load = 1'b1;
        end
        mtpr_pkg::ADDR_CNT_LO: begin
          // The counter low byte cannot be written.
        end
        mtpr_pkg::ADDR_CMP_HI: begin
          shadow_regs[mtpr_pkg::ADDR_STATUS] &= ~mtpr_pkg::FLAG_OCF;
          shadow_compare[15:8] = a.write_data;
          shadow_regs[a.reg_addr] = a.write_data;
        end
        mtpr_pkg::ADDR_CMP_LO: begin
          shadow_regs[mtpr_pkg::ADDR_STATUS] &= ~mtpr_pkg::FLAG_OCF;
          shadow_compare[7:0] = a.write_data;
          shadow_regs[a.reg_addr] = a.write_data;
        end
        default: begin
          shadow_regs[a.reg_addr] = a.write_data;
        end
      endcase
    end else begin
      case (a.reg_addr)
        mtpr_pkg::ADDR_PORT2: begin
          r.read_data = a.port_two_in;
        end
        mtpr_pkg::ADDR_CNT_HI: begin
          shadow_regs[mtpr_pkg::ADDR_STATUS] &= ~mtpr_pkg::FLAG_TOF;
          shadow_latch = a.counter_now[7:0];
          r.read_data = a.counter_now[15:8];
        end
        mtpr_pkg::ADDR_CNT_LO: begin
          r.read_data = shadow_latch;
        end
        default: begin
          r.read_data = shadow_regs[a.reg_addr];
        end
      endcase
    end
    r.compare_value = shadow_compare;
    r.column_select = shadow_regs[mtpr_pkg::ADDR_PORT1];
    return r;
  endfunction

  // The idling pattern moves on after each third of the requests.
  function automatic idle_mode_t current_idle_mode();
    if (accepted_count * 3 < total_accesses) return SENDER_LIGHT;
    if (accepted_count * 3 < total_accesses * 2) return RECEIVER_LIGHT;
    return NO_IDLING;
  endfunction

  function automatic int sender_idle_pct();
    case (current_idle_mode())
      SENDER_LIGHT:   return 10;
      RECEIVER_LIGHT: return 85;
      default:        return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct();
    case (current_idle_mode())
      SENDER_LIGHT:   return 85;
      RECEIVER_LIGHT: return 10;
      default:        return 0;
    endcase
  endfunction

  task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
    if (error_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    end
    error_count++;
  endtask

  task automatic queue_access(logic cmd, logic [4:0] addr, logic [7:0] data,
                              logic [15:0] counter, logic [7:0] port2);
    pending_accesses.push_back({cmd, addr, data, counter, port2});
  endtask

  // Driver: presents the next pending request, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid       <= 1'b0;
      req_if.cmd         <= CMD_READ;
      req_if.reg_addr    <= '0;
      req_if.write_data  <= '0;
      req_if.counter_now <= '0;
      req_if.port_two_in <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_accesses.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
        next_access = pending_accesses.pop_front();
        req_if.valid       <= 1'b1;
        req_if.cmd         <= next_access.cmd;
        req_if.reg_addr    <= next_access.reg_addr;
        req_if.write_data  <= next_access.write_data;
        req_if.counter_now <= next_access.counter_now;
        req_if.port_two_in <= next_access.port_two_in;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Prediction: every accepted request yields exactly one expected result.
  always @(posedge clk) begin
    if (!rst && req_if.valid && req_if.ready) begin
      expected_results.push_back(apply_access(req_seen));
      accepted_count++;
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    mtpr_pkg::rsp_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", rsp_seen.compare_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (rsp_seen.read_data !== want.read_data)
            report_mismatch("read_data", {8'h00, rsp_seen.read_data},
                            {8'h00, want.read_data});
          if (rsp_seen.counter_load !== want.counter_load)
            report_mismatch("counter_load", {15'h0000, rsp_seen.counter_load},
                            {15'h0000, want.counter_load});
          if (rsp_seen.compare_value !== want.compare_value)
            report_mismatch("compare_value", rsp_seen.compare_value, want.compare_value);
          if (rsp_seen.column_select !== want.column_select)
            report_mismatch("column_select", {8'h00, rsp_seen.column_select},
                            {8'h00, want.column_select});
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // Watchdog: gives up when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [4:0] addr;
    int hot;

    // Reset from time zero, with an empty shadow window.
    rst = 1'b1;
    for (int i = 0; i < mtpr_pkg::FILE_DEPTH; i++) shadow_regs[i] = '0;
    shadow_latch = '0;
    shadow_compare = '0;

    // Directed part: the special addresses and the extremes of each field.
    queue_access(CMD_READ,            mtpr_pkg::ADDR_PORT1,  8'h00, 16'h0000, 8'h00);
    queue_access(CMD_READ,            mtpr_pkg::ADDR_CNT_LO, 8'hFF, 16'h1234, 8'h00);
    queue_access(mtpr_pkg::CMD_WRITE, mtpr_pkg::ADDR_STATUS, 8'hFF, 16'hFFFF, 8'hFF);
    queue_access(CMD_READ,            mtpr_pkg::ADDR_STATUS, 8'h00, 16'h0000, 8'h00);
    queue_access(mtpr_pkg::CMD_WRITE, mtpr_pkg::ADDR_STATUS, 8'hE0, 16'h0000, 8'h00);
    queue_access(CMD_READ,            mtpr_pkg::ADDR_STATUS, 8'hFF, 16'h0000, 8'hFF);
    queue_access(mtpr_pkg::CMD_WRITE, mtpr_pkg::ADDR_CNT_HI, 8'h5A, 16'h0000, 8'h00);
    queue_access(mtpr_pkg::CMD_WRITE, mtpr_pkg::ADDR_CNT_LO, 8'hAA, 16'h0000, 8'h00);
    queue_access(CMD_READ,            mtpr_pkg::ADDR_CNT_HI, 8'h00, 16'hFFFF, 8'h00);
    queue_access(CMD_READ,            mtpr_pkg::ADDR_CNT_LO, 8'h00, 16'h0000, 8'h00);
    queue_access(CMD_READ,            mtpr_pkg::ADDR_CNT_HI, 8'h00, 16'h0000, 8'hFF);
    queue_access(CMD_READ,            mtpr_pkg::ADDR_CNT_LO, 8'h00, 16'hFFFF, 8'h00);
    queue_access(mtpr_pkg::CMD_WRITE, mtpr_pkg::ADDR_CMP_HI, 8'hFF, 16'h0000, 8'h00);
    queue_access(mtpr_pkg::CMD_WRITE, mtpr_pkg::ADDR_CMP_LO, 8'h00, 16'h0000, 8'h00);
    queue_access(mtpr_pkg::CMD_WRITE, mtpr_pkg::ADDR_CMP_LO, 8'hFF, 16'h0000, 8'h00);
    queue_access(mtpr_pkg::CMD_WRITE, mtpr_pkg::ADDR_CMP_HI, 8'h00, 16'h0000, 8'h00);
    queue_access(CMD_READ,            mtpr_pkg::ADDR_CMP_HI, 8'h00, 16'h0000, 8'h00);
    queue_access(CMD_READ,            mtpr_pkg::ADDR_CMP_LO, 8'h00, 16'h0000, 8'h00);
    queue_access(CMD_READ,            mtpr_pkg::ADDR_PORT2,  8'h00, 16'h0000, 8'hFF);
    queue_access(CMD_READ,            mtpr_pkg::ADDR_PORT2,  8'hFF, 16'hFFFF, 8'h00);
    queue_access(mtpr_pkg::CMD_WRITE, mtpr_pkg::ADDR_PORT1,  8'hFF, 16'h0000, 8'h00);
    queue_access(mtpr_pkg::CMD_WRITE, 5'h1F,                 8'hA5, 16'h0000, 8'h00);
    queue_access(CMD_READ,            5'h1F,                 8'h00, 16'h0000, 8'h00);
    queue_access(mtpr_pkg::CMD_WRITE, 5'h00,                 8'h00, 16'h0000, 8'h00);
    queue_access(mtpr_pkg::CMD_WRITE, mtpr_pkg::ADDR_PORT1,  8'h00, 16'h0000, 8'h00);

    // Random part, with the special addresses favoured.
    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      if ($urandom_range(99) < 45) begin
        hot = $urandom_range(6);
        case (hot)
          0:       addr = mtpr_pkg::ADDR_PORT1;
          1:       addr = mtpr_pkg::ADDR_PORT2;
          2:       addr = mtpr_pkg::ADDR_STATUS;
          3:       addr = mtpr_pkg::ADDR_CNT_HI;
          4:       addr = mtpr_pkg::ADDR_CNT_LO;
          5:       addr = mtpr_pkg::ADDR_CMP_HI;
          default: addr = mtpr_pkg::ADDR_CMP_LO;
        endcase
      end else begin
        addr = 5'($urandom_range(31));
      end
      queue_access(1'($urandom_range(1)), addr, 8'($urandom_range(255)),
                   16'($urandom_range(65535)), 8'($urandom_range(255)));
    end
    total_accesses = pending_accesses.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to go in and every result to come back.
    while (pending_accesses.size() != 0 || req_if.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
